// ===== hw/rtl/ica_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval capacity admission package
// Shared widths, codes, state type and structs of the admission core.
// ----------------------------------------------------------------------------
`default_nettype none

package ica_pkg;

  localparam int unsigned PosW = 11;
  localparam int unsigned OccW = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgPositionsInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCapacity = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StQueryRead,
    StQueryCompare,
    StDecide,
    StUpdateRead,
    StUpdateWrite,
    StDone
  } state_e;

  typedef struct packed {
    logic [PosW-1:0] positions_in_use;
    logic [OccW-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic            admitted;
    logic [OccW-1:0] peak_occupancy;
    logic [OccW-1:0] admitted_count;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ica_if.sv =====
// ----------------------------------------------------------------------------
// Interval capacity admission channels
// Request, response and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ica_req_if;
  logic                      valid;
  logic                      ready;
  logic [ica_pkg::PosW-1:0]  start_position;
  logic [ica_pkg::PosW-1:0]  end_position;
  modport source (output valid, start_position, end_position, input ready);
  modport sink (input valid, start_position, end_position, output ready);
endinterface

interface ica_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      admitted;
  logic [ica_pkg::OccW-1:0]  peak_occupancy;
  logic [ica_pkg::OccW-1:0]  admitted_count;
  modport source (output valid, admitted, peak_occupancy, admitted_count, input ready);
  modport sink (input valid, admitted, peak_occupancy, admitted_count, output ready);
endinterface

interface ica_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ica_pkg::CfgIdxW-1:0]  index;
  logic [ica_pkg::OccW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ica_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ica_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ica_engine.sv =====
// ----------------------------------------------------------------------------
// Interval capacity admission engine
// Scans the occupancy memory for the peak, increments it on admission.
// ----------------------------------------------------------------------------
`default_nettype none

module ica_engine #(
  parameter int unsigned POSITIONS = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [ica_pkg::PosW-1:0] start_position_i,
  input  wire logic [ica_pkg::PosW-1:0] end_position_i,
  input  wire ica_pkg::cfg_t            cfg_i,
  input  wire logic                     out_free_i,
  output logic                          idle_o,
  output logic                          done_o,
  output ica_pkg::result_t              result_o
);

  localparam int unsigned AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned LW = (AW + 1 > ica_pkg::PosW) ? AW + 1 : ica_pkg::PosW;
  localparam int unsigned CW = LW + 1;

  ica_pkg::state_e state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d, first_q, first_d, last_q, last_d;
  logic [ica_pkg::OccW-1:0] peak_q, peak_d, total_q, total_d, rdata;
  logic admit_q, admit_d;
  logic [CW-1:0] ptr_m1, end_ext;
  logic [LW-1:0] piu_ext, limit;
  logic we;
  logic [AW-1:0] addr;
  logic [ica_pkg::OccW-1:0] wdata;

  assign piu_ext = LW'(cfg_i.positions_in_use);
  assign limit = (piu_ext > LW'(POSITIONS)) ? LW'(POSITIONS) : piu_ext;
  assign end_ext = CW'(end_position_i);
  assign ptr_m1 = ptr_q - CW'(1);

  ica_ram #(.Width(ica_pkg::OccW), .Depth(POSITIONS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ica_pkg::StClear;
      ptr_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q <= last_d;
    peak_q <= peak_d;
    admit_q <= admit_d;
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    first_d = first_q;
    last_d = last_q;
    peak_d = peak_q;
    admit_d = admit_q;
    total_d = total_q;
    we = 1'b0;
    addr = ptr_m1[AW-1:0];
    wdata = rdata + ica_pkg::OccW'(1);
    idle_o = 1'b0;
    done_o = 1'b0;
    case (state_q)
      ica_pkg::StClear: begin
        we = 1'b1;
        addr = ptr_q[AW-1:0];
        wdata = '0;
        ptr_d = ptr_q + CW'(1);
        if (ptr_q == CW'(POSITIONS - 1)) begin
          state_d = ica_pkg::StIdle;
        end
      end
      ica_pkg::StIdle: begin
        idle_o = 1'b1;
        if (start_i) begin
          ptr_d = CW'(start_position_i) + CW'(1);
          first_d = CW'(start_position_i) + CW'(1);
          last_d = (end_ext < CW'(limit)) ? end_ext : CW'(limit);
          peak_d = '0;
          state_d = ica_pkg::StQueryRead;
        end
      end
      ica_pkg::StQueryRead: begin
        if (ptr_q > last_q) begin
          state_d = ica_pkg::StDecide;
        end else begin
          state_d = ica_pkg::StQueryCompare;
        end
      end
      ica_pkg::StQueryCompare: begin
        if (rdata > peak_q) begin
          peak_d = rdata;
        end
        ptr_d = ptr_q + CW'(1);
        state_d = ica_pkg::StQueryRead;
      end
      ica_pkg::StDecide: begin
        admit_d = peak_q < cfg_i.capacity;
        ptr_d = first_q;
        if (peak_q < cfg_i.capacity) begin
          if (total_q != '1) begin
            total_d = total_q + ica_pkg::OccW'(1);
          end
          state_d = ica_pkg::StUpdateRead;
        end else begin
          state_d = ica_pkg::StDone;
        end
      end
      ica_pkg::StUpdateRead: begin
        if (ptr_q > last_q) begin
          state_d = ica_pkg::StDone;
        end else begin
          state_d = ica_pkg::StUpdateWrite;
        end
      end
      ica_pkg::StUpdateWrite: begin
        we = 1'b1;
        ptr_d = ptr_q + CW'(1);
        state_d = ica_pkg::StUpdateRead;
      end
      ica_pkg::StDone: begin
        if (out_free_i) begin
          done_o = 1'b1;
          state_d = ica_pkg::StIdle;
        end
      end
      default: begin
        state_d = ica_pkg::StIdle;
      end
    endcase
  end

  assign result_o.admitted = admit_q;
  assign result_o.peak_occupancy = peak_q;
  assign result_o.admitted_count = total_q;

endmodule

`default_nettype wire

// ===== hw/rtl/interval_capacity_admission_core.sv =====
// ----------------------------------------------------------------------------
// Interval capacity admission core
// Admits interval requests whose peak occupancy stays below the capacity.
// ----------------------------------------------------------------------------
// After reset the core clears its occupancy memory and takes no request
// meanwhile. One memory port reads each covered position for the peak and,
// when the request is admitted, reads and rewrites it for the increment. A
// response register lets the next request enter while the previous response
// waits.
`default_nettype none

module interval_capacity_admission_core #(
  parameter int unsigned POSITIONS = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ica_req_if.sink    req_i,
  ica_rsp_if.source  rsp_o,
  ica_cfg_if.sink    cfg_i
);

  ica_pkg::cfg_t cfg_q;
  ica_pkg::result_t result, rsp_q;
  logic rsp_valid_q, idle, done, out_free;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = idle;
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.positions_in_use <= ica_pkg::PosW'(1024);
      cfg_q.capacity <= ica_pkg::OccW'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          ica_pkg::CfgPositionsInUse: cfg_q.positions_in_use <= cfg_i.data[ica_pkg::PosW-1:0];
          ica_pkg::CfgCapacity: cfg_q.capacity <= cfg_i.data;
          default: begin
          end
        endcase
      end
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= result;
    end
  end

  ica_engine #(.POSITIONS(POSITIONS)) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (req_i.valid && idle),
    .start_position_i(req_i.start_position),
    .end_position_i  (req_i.end_position),
    .cfg_i           (cfg_q),
    .out_free_i      (out_free),
    .idle_o          (idle),
    .done_o          (done),
    .result_o        (result)
  );

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.admitted = rsp_q.admitted;
  assign rsp_o.peak_occupancy = rsp_q.peak_occupancy;
  assign rsp_o.admitted_count = rsp_q.admitted_count;

endmodule

`default_nettype wire

// ===== hw/rtl/ica_checker.sv =====
// ----------------------------------------------------------------------------
// Interval capacity admission checker
// Port-level assertions on the admission core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ica_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     req_valid_i,
  input wire logic                     req_ready_i,
  input wire logic                     rsp_valid_i,
  input wire logic                     rsp_ready_i,
  input wire logic                     rsp_admitted_i,
  input wire logic [ica_pkg::OccW-1:0] rsp_peak_i,
  input wire logic [ica_pkg::OccW-1:0] rsp_count_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_admitted_i)
      && $stable(rsp_peak_i) && $stable(rsp_count_i))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  a_admit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_admitted_i |-> rsp_count_i != '0)
    else $error("admitted response with zero count");

  a_peak_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_admitted_i |-> rsp_peak_i != '1)
    else $error("admitted at full occupancy");

endmodule

bind interval_capacity_admission_core ica_checker u_ica_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_admitted_i(rsp_o.admitted),
  .rsp_peak_i    (rsp_o.peak_occupancy),
  .rsp_count_i   (rsp_o.admitted_count)
);

`default_nettype wire

// ===== bench/interval_capacity_admission_core_tb.sv =====
// ----------------------------------------------------------------------------
// Interval capacity admission core testbench
// Sends interval requests through a directed table and then random phases
// under several register settings. Every response is compared field by field
// against the table row or an in-bench model of occupancy and admitted count.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_capacity_admission_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Positions = 1024;
  localparam int unsigned CycleLimit = 40000000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned RandomItems = 1750;

  typedef struct packed {
    logic [ica_pkg::PosW-1:0] pos_cfg;
    logic [ica_pkg::OccW-1:0] cap_cfg;
    logic [ica_pkg::PosW-1:0] s;
    logic [ica_pkg::PosW-1:0] e;
    logic                     typed;
    logic                     adm;
    logic [ica_pkg::OccW-1:0] peak;
    logic [ica_pkg::OccW-1:0] cnt;
  } dir_row_t;

  localparam int NumDir = 17;
  localparam dir_row_t DirRows [NumDir] = '{
    '{11'd1024, 16'd1, 11'd0, 11'd1024, 1'b1, 1'b1, 16'd0, 16'd1},
    '{11'd1024, 16'd1, 11'd0, 11'd1024, 1'b1, 1'b0, 16'd1, 16'd1},
    '{11'd1024, 16'd1, 11'd5, 11'd5, 1'b1, 1'b1, 16'd0, 16'd2},
    '{11'd1024, 16'd1, 11'd1024, 11'd0, 1'b1, 1'b1, 16'd0, 16'd3},
    '{11'd1024, 16'd1, 11'd2047, 11'd2047, 1'b1, 1'b1, 16'd0, 16'd4},
    '{11'd1024, 16'd1, 11'd0, 11'd2047, 1'b1, 1'b0, 16'd1, 16'd4},
    '{11'd1024, 16'd1, 11'd1023, 11'd1024, 1'b1, 1'b0, 16'd1, 16'd4},
    '{11'd1024, 16'd1, 11'd0, 11'd1, 1'b1, 1'b0, 16'd1, 16'd4},
    '{11'd1024, 16'd0, 11'd0, 11'd0, 1'b1, 1'b0, 16'd0, 16'd4},
    '{11'd1024, 16'd0, 11'd0, 11'd1024, 1'b1, 1'b0, 16'd1, 16'd4},
    '{11'd1024, 16'd0, 11'd10, 11'd20, 1'b1, 1'b0, 16'd1, 16'd4},
    '{11'd0, 16'd2, 11'd0, 11'd1024, 1'b1, 1'b1, 16'd0, 16'd5},
    '{11'd2047, 16'd2, 11'd0, 11'd2047, 1'b1, 1'b1, 16'd1, 16'd6},
    '{11'd2047, 16'd2, 11'd0, 11'd3, 1'b1, 1'b0, 16'd2, 16'd6},
    '{11'd1, 16'd2, 11'd0, 11'd1, 1'b1, 1'b0, 16'd2, 16'd6},
    '{11'd1, 16'd2, 11'd1, 11'd5, 1'b1, 1'b1, 16'd0, 16'd7},
    '{11'd1024, 16'd65535, 11'd100, 11'd200, 1'b0, 1'b0, 16'd0, 16'd0}
  };

  localparam int NumPhases = 9;
  localparam logic [ica_pkg::PosW-1:0] PhasePos [NumPhases] =
    '{11'd1024, 11'd16, 11'd1, 11'd0, 11'd2047, 11'd300, 11'd1024, 11'd64, 11'd1000};
  localparam logic [ica_pkg::OccW-1:0] PhaseCap [NumPhases] =
    '{16'd3, 16'd2, 16'd5, 16'd4, 16'd65535, 16'd1, 16'd65535, 16'd10, 16'd7};

  logic clk;
  logic rst_n;

  ica_req_if req ();
  ica_rsp_if rsp ();
  ica_cfg_if cfg ();

  interval_capacity_admission_core #(.POSITIONS(Positions)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  logic [ica_pkg::OccW-1:0] occ [Positions];
  logic [ica_pkg::OccW-1:0] admitted_total;
  logic [ica_pkg::PosW-1:0] model_positions;
  logic [ica_pkg::OccW-1:0] model_capacity;
  ica_pkg::result_t         pending_results [$];
  int unsigned              mismatches;
  int unsigned              cycles;
  bit                       burst_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ica_pkg::result_t admit_request(logic [ica_pkg::PosW-1:0] s,
                                                     logic [ica_pkg::PosW-1:0] e);
    int unsigned lim;
    int unsigned first;
    int unsigned last;
    logic [ica_pkg::OccW-1:0] peak;
    ica_pkg::result_t r;
    lim = (model_positions > Positions) ? Positions : model_positions;
    first = s + 1;
    last = (e < lim) ? e : lim;
    peak = '0;
    for (int unsigned p = first; p <= last; p++) begin
      if (occ[p-1] > peak) peak = occ[p-1];
    end
    r.admitted = (peak < model_capacity);
    r.peak_occupancy = peak;
    if (r.admitted) begin
      for (int unsigned p = first; p <= last; p++) occ[p-1] = occ[p-1] + 1'b1;
      if (admitted_total != 16'hFFFF) admitted_total = admitted_total + 1'b1;
    end
    r.admitted_count = admitted_total;
    return r;
  endfunction

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (burst_mode || roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic write_reg(logic [ica_pkg::CfgIdxW-1:0] idx,
                           logic [ica_pkg::OccW-1:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    if (idx == ica_pkg::CfgPositionsInUse) model_positions = value[ica_pkg::PosW-1:0];
    else model_capacity = value;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_regs(logic [ica_pkg::PosW-1:0] pos_value,
                          logic [ica_pkg::OccW-1:0] cap_value);
    wait_idle();
    write_reg(ica_pkg::CfgPositionsInUse, {5'($urandom), pos_value});
    write_reg(ica_pkg::CfgCapacity, cap_value);
  endtask

  task automatic send_request(logic [ica_pkg::PosW-1:0] s, logic [ica_pkg::PosW-1:0] e,
                              bit typed, ica_pkg::result_t typed_result);
    int unsigned gap;
    ica_pkg::result_t r;
    gap = gap_length();
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.start_position = s;
    req.end_position = e;
    do @(posedge clk); while (!req.ready);
    r = admit_request(s, e);
    if (typed) r = typed_result;
    pending_results = {pending_results, r};
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic random_request(int unsigned lim);
    int unsigned roll;
    int unsigned s;
    int unsigned e;
    roll = $urandom_range(99);
    if (roll < 85) begin
      s = (lim == 0) ? 0 : $urandom_range(lim - 1);
      e = s + $urandom_range(32, 1);
    end else if (roll < 88) begin
      s = $urandom_range(64);
      e = $urandom_range(1024);
    end else begin
      s = $urandom_range(2047);
      e = $urandom_range(2047);
      if (s < e && e - s > 64) e = s + $urandom_range(64);
    end
    send_request(ica_pkg::PosW'(s), ica_pkg::PosW'(e), 1'b0, '0);
  endtask

  initial begin
    req.valid = 1'b0;
    req.start_position = '0;
    req.end_position = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    rst_n = 1'b0;
    burst_mode = 1'b0;
    mismatches = 0;
    admitted_total = '0;
    model_positions = 11'd1024;
    model_capacity = 16'd1;
    foreach (occ[i]) occ[i] = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (DirRows[i]) begin
      if (DirRows[i].pos_cfg != model_positions || DirRows[i].cap_cfg != model_capacity) begin
        set_regs(DirRows[i].pos_cfg, DirRows[i].cap_cfg);
      end
      send_request(DirRows[i].s, DirRows[i].e, DirRows[i].typed,
                   '{DirRows[i].adm, DirRows[i].peak, DirRows[i].cnt});
    end
    req.valid = 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_regs(PhasePos[ph], PhaseCap[ph]);
      burst_mode = (ph % 3 == 1);
      for (int n = 0; n < RandomItems / NumPhases; n++) begin
        random_request((model_positions > Positions) ? Positions : model_positions);
      end
      req.valid = 1'b0;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int unsigned run;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(20, 1);
      @(negedge clk);
      rsp.ready = 1'b1;
      repeat (run - 1) @(negedge clk);
      if (!burst_mode) begin
        run = ($urandom_range(99) < 5) ? $urandom_range(100, 20) : $urandom_range(3);
        if (run > 0) begin
          @(negedge clk);
          rsp.ready = 1'b0;
          repeat (run - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    ica_pkg::result_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.admitted !== exp_r.admitted) begin
          $error("admitted: expected %0d, got %0d", exp_r.admitted, rsp.admitted);
          mismatches++;
        end
        if (rsp.peak_occupancy !== exp_r.peak_occupancy) begin
          $error("peak_occupancy: expected %0d, got %0d",
                 exp_r.peak_occupancy, rsp.peak_occupancy);
          mismatches++;
        end
        if (rsp.admitted_count !== exp_r.admitted_count) begin
          $error("admitted_count: expected %0d, got %0d",
                 exp_r.admitted_count, rsp.admitted_count);
          mismatches++;
        end
      end
    end
  end

  initial cycles = 0;

endmodule

`default_nettype wire

// ===== interval_capacity_admission_core.f =====
hw/rtl/ica_pkg.sv
hw/rtl/ica_if.sv
hw/rtl/ica_ram.sv
hw/rtl/ica_engine.sv
hw/rtl/interval_capacity_admission_core.sv
hw/rtl/ica_checker.sv
bench/interval_capacity_admission_core_tb.sv
